>>> hdl/sspr_pkg.sv
// Package: shared types and constants for the servo status packet receiver.
`timescale 1ns / 1ps
`default_nettype none
package sspr_pkg;

  localparam logic [7:0] SYNC_BYTE = 8'hFF;
  localparam logic [7:0] ANY_ID    = 8'hFE;
  localparam logic [7:0] SUM_GOOD  = 8'hFF;
  localparam logic [8:0] LEN_EXTRA = 9'd2;

  localparam logic [7:0] EXPECTED_ID_RST     = ANY_ID;
  localparam logic [7:0] EXPECTED_PARAMS_RST = 8'd0;

  typedef enum logic [0:0] {
    REG_EXPECTED_ID     = 1'b0,
    REG_EXPECTED_PARAMS = 1'b1
  } reg_idx_e;

  typedef enum logic [2:0] {
    PH_HUNT1   = 3'd0,
    PH_HUNT2   = 3'd1,
    PH_ID      = 3'd2,
    PH_LEN     = 3'd3,
    PH_ERR     = 3'd4,
    PH_PAYLOAD = 3'd5,
    PH_CHECK   = 3'd6
  } phase_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BAD_SUM = 2'd1,
    ST_BAD_LEN = 2'd2
  } status_e;

  typedef struct packed {
    logic [7:0] expected_id;
    logic [7:0] expected_params;
  } cfg_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       frame_end;
    status_e    status;
    logic [7:0] motor_id;
    logic [7:0] error_code;
  } result_t;

endpackage
`default_nettype wire

>>> hdl/sspr_cfg.sv
// Configuration registers: expected id and expected payload length.
`timescale 1ns / 1ps
`default_nettype none
module sspr_cfg
  import sspr_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_valid_i,
  input  wire logic [0:0] cfg_index_i,
  input  wire logic [7:0] cfg_data_i,
  output cfg_t            cfg_o
);

  cfg_t cfg_q;
  cfg_t cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (reg_idx_e'(cfg_index_i))
        REG_EXPECTED_ID:     cfg_d.expected_id     = cfg_data_i;
        REG_EXPECTED_PARAMS: cfg_d.expected_params = cfg_data_i;
        default:             cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.expected_id     <= EXPECTED_ID_RST;
      cfg_q.expected_params <= EXPECTED_PARAMS_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

>>> hdl/sspr_parser.sv
// Frame parser: phase state machine, header fields, checksum and payload count.
`timescale 1ns / 1ps
`default_nettype none
module sspr_parser
  import sspr_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       take_i,
  input  wire logic [7:0] byte_i,
  input  cfg_t            cfg_i,
  output logic            res_valid_o,
  output result_t         res_o
);

  phase_e     phase_q, phase_d;
  logic [7:0] frame_id_q, frame_id_d;
  logic [7:0] length_q, length_d;
  logic [7:0] error_q, error_d;
  logic [7:0] sum_q, sum_d;
  logic [7:0] count_q, count_d;

  logic [7:0] sum_add;
  logic [8:0] count_next;
  logic       id_ok;
  logic       len_ok;

  assign sum_add    = sum_q + byte_i;
  assign count_next = {1'b0, count_q} + 9'd1;
  assign id_ok      = (cfg_i.expected_id == ANY_ID) || (frame_id_q == cfg_i.expected_id);
  assign len_ok     = {1'b0, length_q} == ({1'b0, cfg_i.expected_params} + LEN_EXTRA);

  always_comb begin
    phase_d    = phase_q;
    frame_id_d = frame_id_q;
    length_d   = length_q;
    error_d    = error_q;
    sum_d      = sum_q;
    count_d    = count_q;
    res_valid_o = 1'b0;
    res_o.out_byte   = byte_i;
    res_o.frame_end  = 1'b0;
    res_o.status     = ST_OK;
    res_o.motor_id   = frame_id_q;
    res_o.error_code = error_q;
    if (take_i) begin
      unique case (phase_q)
        PH_HUNT1: begin
          if (byte_i == SYNC_BYTE) phase_d = PH_HUNT2;
        end
        PH_HUNT2: begin
          phase_d = (byte_i == SYNC_BYTE) ? PH_ID : PH_HUNT1;
        end
        PH_ID: begin
          if (byte_i != SYNC_BYTE) begin
            frame_id_d = byte_i;
            sum_d      = byte_i;
            phase_d    = PH_LEN;
          end
        end
        PH_LEN: begin
          length_d = byte_i;
          sum_d    = sum_add;
          phase_d  = PH_ERR;
        end
        PH_ERR: begin
          error_d = byte_i;
          sum_d   = sum_add;
          count_d = 8'd0;
          if (!id_ok) begin
            phase_d = PH_HUNT1;
          end else if (cfg_i.expected_params == 8'd0) begin
            phase_d = PH_CHECK;
          end else begin
            phase_d = PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          sum_d   = sum_add;
          count_d = count_next[7:0];
          if (count_next >= {1'b0, cfg_i.expected_params}) phase_d = PH_CHECK;
          res_valid_o = 1'b1;
        end
        PH_CHECK: begin
          sum_d   = sum_add;
          phase_d = PH_HUNT1;
          res_valid_o     = 1'b1;
          res_o.out_byte  = 8'd0;
          res_o.frame_end = 1'b1;
          priority if (!len_ok)             res_o.status = ST_BAD_LEN;
          else if (sum_add != SUM_GOOD)     res_o.status = ST_BAD_SUM;
          else                              res_o.status = ST_OK;
        end
        default: phase_d = PH_HUNT1;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_HUNT1;
      frame_id_q <= 8'd0;
      length_q   <= 8'd0;
      error_q    <= 8'd0;
      sum_q      <= 8'd0;
      count_q    <= 8'd0;
    end else begin
      phase_q    <= phase_d;
      frame_id_q <= frame_id_d;
      length_q   <= length_d;
      error_q    <= error_d;
      sum_q      <= sum_d;
      count_q    <= count_d;
    end
  end

endmodule
`default_nettype wire

>>> hdl/sspr_out_reg.sv
// Result register: holds one result item until the consumer takes it.
`timescale 1ns / 1ps
`default_nettype none
module sspr_out_reg
  import sspr_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic load_i,
  input  wire logic res_valid_i,
  input  result_t   res_i,
  input  wire logic out_stall_i,
  output logic      advance_o,
  output logic      out_valid_o,
  output result_t   out_o
);

  logic    valid_q, valid_d;
  result_t data_q;

  assign advance_o = !valid_q || !out_stall_i;
  assign valid_d   = advance_o ? (load_i && res_valid_i) : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o && load_i && res_valid_i) begin
      data_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_o       = data_q;

endmodule
`default_nettype wire

>>> hdl/servo_status_packet_receiver_top.sv
// Top level: servo status packet receiver with input register and result register.
//
//  Channel | Direction | Handshake           | Payload
//  --------+-----------+---------------------+---------------------------------------
//  in      | in        | in_valid_i/in_stall_o | rx_byte_i
//  out     | out       | out_valid_o/out_stall_i | out_byte_o, frame_end_o, status_o,
//          |           |                     | motor_id_o, error_code_o
//  cfg     | in        | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// One item per cycle sustained while out is not stalled; an accepted byte passes from the
// input register through the parser logic into the result register, whose item is on out.
// Reset clears the phase, header fields, checksum, count and valid flags; no clearing pass.
// Stall on out holds the result register and backs up into the input register,
// so in_stall_o rises only when both are full.
`timescale 1ns / 1ps
`default_nettype none
module servo_status_packet_receiver_top
  import sspr_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] rx_byte_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [7:0]      out_byte_o,
  output logic            frame_end_o,
  output logic [1:0]      status_o,
  output logic [7:0]      motor_id_o,
  output logic [7:0]      error_code_o,
  input  wire logic       cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire logic [0:0] cfg_index_i,
  input  wire logic [7:0] cfg_data_i
);

  logic       in_valid_q, in_valid_d;
  logic [7:0] in_byte_q;
  logic       advance;
  logic       take;
  logic       res_valid;
  result_t    res;
  result_t    out_res;
  cfg_t       cfg;

  assign cfg_ready_o = 1'b1;

  sspr_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  assign take       = in_valid_q && advance;
  assign in_stall_o = in_valid_q && !advance;
  assign in_valid_d = in_stall_o ? in_valid_q : in_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      in_byte_q <= rx_byte_i;
    end
  end

  sspr_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (take),
    .byte_i      (in_byte_q),
    .cfg_i       (cfg),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  sspr_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (take),
    .res_valid_i (res_valid),
    .res_i       (res),
    .out_stall_i (out_stall_i),
    .advance_o   (advance),
    .out_valid_o (out_valid_o),
    .out_o       (out_res)
  );

  assign out_byte_o   = out_res.out_byte;
  assign frame_end_o  = out_res.frame_end;
  assign status_o     = out_res.status;
  assign motor_id_o   = out_res.motor_id;
  assign error_code_o = out_res.error_code;

  a_end_zero_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_end_o |-> out_byte_o == 8'd0)
    else $error("end item carries a nonzero byte");

  a_status_only_on_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !frame_end_o |-> status_o == ST_OK)
    else $error("payload item carries a status");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled while result register can drain");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o != 2'd3)
    else $error("status code out of range");

endmodule
`default_nettype wire

>>> bench/servo_status_packet_receiver_top_tb.sv
// Testbench for the servo status packet receiver: byte driver, result monitor, frame predictor.
`timescale 1ns / 1ps
module servo_status_packet_receiver_top_tb;
  import sspr_pkg::*;

  localparam int CLK_PERIOD = 12;
  localparam int RST_CYCLES = 11;
  localparam int IDLE_PCT   = 12;
  localparam int SETTLE     = 6;
  localparam int LIMIT      = 400000;
  localparam int MAX_PRINTS = 40;

  typedef enum int {FR_GOOD, FR_BAD_SUM, FR_BAD_LEN} frame_kind_e;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  logic [7:0] rx_byte_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic [7:0] out_byte_o;
  logic       frame_end_o;
  logic [1:0] status_o;
  logic [7:0] motor_id_o;
  logic [7:0] error_code_o;
  logic       cfg_valid_i;
  logic       cfg_ready_o;
  logic [0:0] cfg_index_i;
  logic [7:0] cfg_data_i;

  servo_status_packet_receiver_top DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .rx_byte_i   (rx_byte_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_byte_o  (out_byte_o),
    .frame_end_o (frame_end_o),
    .status_o    (status_o),
    .motor_id_o  (motor_id_o),
    .error_code_o(error_code_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // predictor state
  cfg_t       prs_cfg;
  phase_e     prs_phase;
  logic [7:0] prs_id;
  logic [7:0] prs_len;
  logic [7:0] prs_err;
  logic [7:0] prs_sum;
  logic [7:0] prs_count;

  logic [7:0] rx_backlog[$];
  result_t    parsed_results[$];

  bit rx_taken;
  bit steady_flow;
  int cycles;
  int errors;
  int bytes_taken;
  int phase_bytes;
  int cfg_writes;
  int payload_seen;
  int frames_dropped;
  int frame_tally[3];

  initial begin
    clk_i = 1'b0;
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    if (errors < MAX_PRINTS)
      $display("[%0t] mismatch %s: got %02h, expected %02h", $realtime, what, got, want);
    errors++;
  endtask

  task automatic parse_rx_byte(input logic [7:0] b);
    logic [8:0] nxt_count;
    result_t    r;
    r = '0;
    r.status = ST_OK;
    case (prs_phase)
      PH_HUNT1: if (b == SYNC_BYTE) prs_phase = PH_HUNT2;
      PH_HUNT2: prs_phase = (b == SYNC_BYTE) ? PH_ID : PH_HUNT1;
      PH_ID: begin
        if (b != SYNC_BYTE) begin
          prs_id    = b;
          prs_sum   = b;
          prs_phase = PH_LEN;
        end
      end
      PH_LEN: begin
        prs_len   = b;
        prs_sum   = prs_sum + b;
        prs_phase = PH_ERR;
      end
      PH_ERR: begin
        prs_err   = b;
        prs_sum   = prs_sum + b;
        prs_count = 8'd0;
        if (prs_cfg.expected_id != ANY_ID && prs_id != prs_cfg.expected_id) begin
          prs_phase = PH_HUNT1;
          frames_dropped++;
        end else begin
          prs_phase = (prs_cfg.expected_params == 8'd0) ? PH_CHECK : PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        nxt_count = {1'b0, prs_count} + 9'd1;
        prs_sum   = prs_sum + b;
        prs_count = nxt_count[7:0];
        if (nxt_count >= {1'b0, prs_cfg.expected_params}) prs_phase = PH_CHECK;
        r.out_byte   = b;
        r.frame_end  = 1'b0;
        r.motor_id   = prs_id;
        r.error_code = prs_err;
        parsed_results.insert(parsed_results.size(), r);
        payload_seen++;
      end
      PH_CHECK: begin
        prs_sum = prs_sum + b;
        if ({1'b0, prs_len} != {1'b0, prs_cfg.expected_params} + LEN_EXTRA)
          r.status = ST_BAD_LEN;
        else if (prs_sum != SUM_GOOD)
          r.status = ST_BAD_SUM;
        else
          r.status = ST_OK;
        prs_phase    = PH_HUNT1;
        r.out_byte   = 8'd0;
        r.frame_end  = 1'b1;
        r.motor_id   = prs_id;
        r.error_code = prs_err;
        parsed_results.insert(parsed_results.size(), r);
        frame_tally[r.status]++;
      end
      default: prs_phase = PH_HUNT1;
    endcase
  endtask

  // byte driver and random output stall
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || rx_taken) begin
        rx_taken = 1'b0;
        if (rx_backlog.size() != 0 && !(!steady_flow && $urandom_range(99) < IDLE_PCT)) begin
          in_valid_i <= 1'b1;
          rx_byte_i  <= rx_backlog.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_stall_i <= !steady_flow && ($urandom_range(99) < IDLE_PCT);
    end
  end

  // accepted bytes feed the predictor
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) begin
      rx_taken = 1'b1;
      parse_rx_byte(rx_byte_i);
      bytes_taken++;
    end
  end

  // result monitor
  always @(posedge clk_i) begin : result_mon
    result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (parsed_results.size() == 0) begin
        report_mismatch("unexpected item out_byte", out_byte_o, 8'd0);
      end else begin
        want = parsed_results.pop_front();
        if (out_byte_o !== want.out_byte)
          report_mismatch("out_byte", out_byte_o, want.out_byte);
        if (frame_end_o !== want.frame_end)
          report_mismatch("frame_end", {7'd0, frame_end_o}, {7'd0, want.frame_end});
        if (status_o !== want.status)
          report_mismatch("status", {6'd0, status_o}, {6'd0, want.status});
        if (motor_id_o !== want.motor_id)
          report_mismatch("motor_id", motor_id_o, want.motor_id);
        if (error_code_o !== want.error_code)
          report_mismatch("error_code", error_code_o, want.error_code);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles, %0d items still expected", cycles,
               parsed_results.size());
      $display("** servo_status_packet_receiver_top: FAILED **");
      $finish;
    end
  end

  task automatic push_rx(input logic [7:0] b);
    rx_backlog.insert(rx_backlog.size(), b);
    phase_bytes++;
  endtask

  task automatic push_frame(input logic [7:0] fid, input int n_payload, input int n_sync,
                            input frame_kind_e kind);
    logic [7:0] len;
    logic [7:0] err;
    logic [7:0] sum;
    logic [7:0] pl;
    logic [7:0] chk;
    logic [7:0] flip;
    len = 8'(n_payload + 2);
    if (kind == FR_BAD_LEN) begin
      flip = 8'($urandom_range(1, 255));
      len  = len + flip;
    end
    err = 8'($urandom);
    sum = fid + len + err;
    repeat (2 + n_sync) push_rx(SYNC_BYTE);
    push_rx(fid);
    push_rx(len);
    push_rx(err);
    repeat (n_payload) begin
      pl  = 8'($urandom);
      sum = sum + pl;
      push_rx(pl);
    end
    chk = ~sum;
    if (kind == FR_BAD_SUM) begin
      flip = 8'($urandom_range(1, 255));
      chk  = chk ^ flip;
    end
    push_rx(chk);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [7:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == REG_EXPECTED_ID) prs_cfg.expected_id = val;
    else prs_cfg.expected_params = val;
    cfg_writes++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // hold the sender until every queued byte is taken and every result is back
  task automatic drain_all();
    while (rx_backlog.size() != 0 || in_valid_i || parsed_results.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  initial begin : stimulus
    logic [7:0]  id_cfg;
    logic [7:0]  par_cfg;
    logic [7:0]  fid;
    logic [7:0]  noise;
    int          r;
    int          n_pl;
    frame_kind_e kind;

    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    rx_byte_i   = 8'd0;
    out_stall_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = REG_EXPECTED_ID;
    cfg_data_i  = 8'd0;
    rx_taken    = 1'b0;
    steady_flow = 1'b0;
    prs_cfg.expected_id     = EXPECTED_ID_RST;
    prs_cfg.expected_params = EXPECTED_PARAMS_RST;
    prs_phase = PH_HUNT1;
    prs_id    = 8'd0;
    prs_len   = 8'd0;
    prs_err   = 8'd0;
    prs_sum   = 8'd0;
    prs_count = 8'd0;
    repeat (RST_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: reset settings accept any id with no payload
    push_rx(SYNC_BYTE);
    push_rx(8'h00);
    push_frame(8'h00, 0, 2, FR_GOOD);
    push_frame(ANY_ID, 0, 0, FR_BAD_SUM);
    push_frame(8'hFD, 0, 0, FR_BAD_LEN);
    drain_all();

    write_reg(REG_EXPECTED_ID, 8'h00);
    write_reg(REG_EXPECTED_PARAMS, 8'd2);
    push_frame(8'h00, 2, 0, FR_GOOD);
    push_frame(8'h07, 2, 0, FR_GOOD);
    // stop inside the payload, then shrink the payload count
    push_rx(SYNC_BYTE);
    push_rx(SYNC_BYTE);
    push_rx(8'h00);
    push_rx(8'h04);
    push_rx(8'h3C);
    push_rx(8'hAA);
    drain_all();
    write_reg(REG_EXPECTED_PARAMS, 8'd1);
    push_rx(8'h55);
    push_rx(8'h6E);
    drain_all();

    write_reg(REG_EXPECTED_ID, ANY_ID);
    write_reg(REG_EXPECTED_PARAMS, 8'd253);
    push_frame(8'h5A, 253, 1, FR_GOOD);
    drain_all();

    // random phases
    for (int ph = 0; ph < 12; ph++) begin
      r = $urandom_range(3);
      id_cfg  = (r == 0) ? ANY_ID : (r == 1) ? 8'h00 : 8'($urandom_range(0, 254));
      par_cfg = ($urandom_range(4) == 0) ? 8'($urandom_range(0, 20)) :
                8'($urandom_range(0, 6));
      if ($urandom_range(1)) begin
        write_reg(REG_EXPECTED_ID, id_cfg);
        write_reg(REG_EXPECTED_PARAMS, par_cfg);
      end else begin
        write_reg(REG_EXPECTED_PARAMS, par_cfg);
        write_reg(REG_EXPECTED_ID, id_cfg);
      end
      steady_flow = (ph == 4);
      phase_bytes = 0;
      while (phase_bytes < 100) begin
        r = $urandom_range(99);
        if (r < 10) begin
          repeat ($urandom_range(1, 4)) begin
            noise = 8'($urandom);
            push_rx(noise);
          end
        end else if (r < 15) begin
          noise = 8'($urandom_range(0, 254));
          push_rx(SYNC_BYTE);
          push_rx(noise);
        end else begin
          if (id_cfg == ANY_ID || $urandom_range(9) == 0) fid = 8'($urandom_range(0, 254));
          else fid = id_cfg;
          n_pl = ($urandom_range(9) == 0) ? $urandom_range(0, 8) : par_cfg;
          r    = $urandom_range(99);
          kind = (r < 80) ? FR_GOOD : (r < 90) ? FR_BAD_SUM : FR_BAD_LEN;
          push_frame(fid, n_pl, ($urandom_range(5) == 0) ? $urandom_range(1, 3) : 0, kind);
        end
        if (ph == 2 && phase_bytes >= 60 && phase_bytes < 66) drain_all();
      end
      drain_all();
      steady_flow = 1'b0;
    end

    drain_all();
    $display("Run covered %0d bytes and %0d register writes across sync, header and payload.",
             bytes_taken, cfg_writes);
    $display("Frames: %0d ok, %0d bad checksum, %0d bad length, %0d dropped; %0d payload.",
             frame_tally[ST_OK], frame_tally[ST_BAD_SUM], frame_tally[ST_BAD_LEN],
             frames_dropped, payload_seen);
    if (errors == 0) begin
      $display("** servo_status_packet_receiver_top: PASSED **");
    end else begin
      $display("** servo_status_packet_receiver_top: FAILED **");
    end
    $finish;
  end

endmodule
